[hw/rtl/kpi_pkg.sv]
`timescale 1ns / 1ps

package kpi_pkg;

  // Sizing of the stores
  localparam int JOINTS    = 16;
  localparam int MAX_STEPS = 64;

  // Fixed field widths
  localparam int ANGLE_W    = 16;
  localparam int TICK_W     = 24;
  localparam int TIME_W     = 32;
  localparam int STEPS_W    = 7;
  localparam int JOINT_W    = 4;
  localparam int STEP_NUM_W = 6;

  // Derived widths
  localparam int JOINT_AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int STEP_AW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int STEP_CW  = $clog2(MAX_STEPS + 1);
  localparam int CMP_W    = (STEP_CW > STEPS_W) ? STEP_CW : STEPS_W;
  localparam int ANGLE_DEPTH = MAX_STEPS * JOINTS;
  localparam int ANGLE_AW = (ANGLE_DEPTH > 1) ? $clog2(ANGLE_DEPTH) : 1;
  localparam int TIM_W    = 2 * TICK_W;
  localparam int DIFF_W   = ANGLE_W + 1;
  localparam int PROD_W   = DIFF_W + TICK_W;
  localparam int QUO_W    = DIFF_W;
  localparam int DCNT_W   = $clog2(QUO_W);

  typedef enum logic [1:0] {
    MODE_TIMING = 2'd0,
    MODE_ANGLE  = 2'd1,
    MODE_START  = 2'd2,
    MODE_QUERY  = 2'd3
  } kpi_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK_CHK,
    ST_WALK_PAUSE,
    ST_WALK_MOVE,
    ST_J_PREV,
    ST_J_TGT,
    ST_J_MUL,
    ST_J_DLOAD,
    ST_J_DIV,
    ST_J_OUT
  } kpi_state_t;

  typedef struct packed {
    kpi_mode_t                mode;
    logic [STEP_NUM_W-1:0]    step_number;
    logic [JOINT_W-1:0]       joint_number;
    logic signed [ANGLE_W-1:0] joint_angle;
    logic [TICK_W-1:0]        pause_ticks;
    logic [TICK_W-1:0]        move_ticks;
    logic [TIME_W-1:0]        query_time;
  } kpi_in_t;

  typedef struct packed {
    logic [JOINT_W-1:0]        out_joint;
    logic signed [ANGLE_W-1:0] out_angle;
    logic                      last_joint;
  } kpi_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_query;
    logic walk_pause;
    logic walk_adv;
    logic set_interp;
    logic prev_sel;
    logic take_prev;
    logic mul;
    logic div_load;
    logic div_step;
    logic emit;
  } kpi_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic hit_pause;
    logic hit_move;
    logic interp;
    logic div_last;
    logic joint_last;
  } kpi_sts_t;

  function automatic logic [ANGLE_AW-1:0] angle_addr(input int step, input int joint);
    angle_addr = ANGLE_AW'(step * JOINTS + joint);
  endfunction

endpackage

[hw/rtl/kpi_ram.sv]
`timescale 1ns / 1ps

module kpi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/kpi_ctrl.sv]
`timescale 1ns / 1ps

module kpi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              query_go,
  input  kpi_pkg::kpi_sts_t sts,
  output kpi_pkg::kpi_cmd_t cmd,
  output logic              busy
);

  kpi_pkg::kpi_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kpi_pkg::ST_IDLE: begin
        if (query_go) state_nxt = kpi_pkg::ST_WALK_CHK;
      end
      kpi_pkg::ST_WALK_CHK: begin
        state_nxt = sts.walk_done ? kpi_pkg::ST_J_PREV : kpi_pkg::ST_WALK_PAUSE;
      end
      kpi_pkg::ST_WALK_PAUSE: begin
        state_nxt = sts.hit_pause ? kpi_pkg::ST_J_PREV : kpi_pkg::ST_WALK_MOVE;
      end
      kpi_pkg::ST_WALK_MOVE: begin
        state_nxt = sts.hit_move ? kpi_pkg::ST_J_PREV : kpi_pkg::ST_WALK_CHK;
      end
      kpi_pkg::ST_J_PREV:  state_nxt = kpi_pkg::ST_J_TGT;
      kpi_pkg::ST_J_TGT: begin
        state_nxt = sts.interp ? kpi_pkg::ST_J_MUL : kpi_pkg::ST_J_OUT;
      end
      kpi_pkg::ST_J_MUL:   state_nxt = kpi_pkg::ST_J_DLOAD;
      kpi_pkg::ST_J_DLOAD: state_nxt = kpi_pkg::ST_J_DIV;
      kpi_pkg::ST_J_DIV: begin
        if (sts.div_last) state_nxt = kpi_pkg::ST_J_OUT;
      end
      kpi_pkg::ST_J_OUT: begin
        state_nxt = sts.joint_last ? kpi_pkg::ST_IDLE : kpi_pkg::ST_J_PREV;
      end
      default: state_nxt = kpi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      kpi_pkg::ST_IDLE:       cmd.load_query = query_go;
      kpi_pkg::ST_WALK_PAUSE: cmd.walk_pause = 1'b1;
      kpi_pkg::ST_WALK_MOVE: begin
        cmd.walk_adv   = !sts.hit_move;
        cmd.set_interp = sts.hit_move;
      end
      kpi_pkg::ST_J_PREV:     cmd.prev_sel  = 1'b1;
      kpi_pkg::ST_J_TGT:      cmd.take_prev = 1'b1;
      kpi_pkg::ST_J_MUL:      cmd.mul       = 1'b1;
      kpi_pkg::ST_J_DLOAD:    cmd.div_load  = 1'b1;
      kpi_pkg::ST_J_DIV:      cmd.div_step  = 1'b1;
      kpi_pkg::ST_J_OUT:      cmd.emit      = 1'b1;
      default:                cmd = '0;
    endcase
  end

  assign busy = (state_r != kpi_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kpi_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The divide path is only taken for a joint inside a move
  a_mul_needs_interp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kpi_pkg::ST_J_MUL |-> sts.interp)
    else $error("multiply entered outside a move");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kpi_pkg::ST_J_DIV && sts.div_last) |=> state_r == kpi_pkg::ST_J_OUT)
    else $error("divider did not hand over to output");

  a_pose_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kpi_pkg::ST_J_OUT && sts.joint_last) |=> !busy)
    else $error("still busy after the final joint");

endmodule

[hw/rtl/kpi_datapath.sv]
`timescale 1ns / 1ps

module kpi_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_accept,
  input  kpi_pkg::kpi_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [kpi_pkg::STEPS_W-1:0]   cfg_wdata,
  input  kpi_pkg::kpi_cmd_t             cmd,
  output kpi_pkg::kpi_sts_t             sts,
  output logic                          out_strobe,
  output kpi_pkg::kpi_out_t             out_data
);

  localparam int JOINTS   = kpi_pkg::JOINTS;
  localparam int ANGLE_W  = kpi_pkg::ANGLE_W;
  localparam int TICK_W   = kpi_pkg::TICK_W;
  localparam int TIME_W   = kpi_pkg::TIME_W;
  localparam int STEP_AW  = kpi_pkg::STEP_AW;
  localparam int STEP_CW  = kpi_pkg::STEP_CW;
  localparam int JOINT_AW = kpi_pkg::JOINT_AW;
  localparam int ANGLE_AW = kpi_pkg::ANGLE_AW;
  localparam int CMP_W    = kpi_pkg::CMP_W;
  localparam int DIFF_W   = kpi_pkg::DIFF_W;
  localparam int PROD_W   = kpi_pkg::PROD_W;
  localparam int QUO_W    = kpi_pkg::QUO_W;
  localparam int DCNT_W   = kpi_pkg::DCNT_W;

  // Configuration and initial pose
  logic [kpi_pkg::STEPS_W-1:0] steps_r, steps_nxt;
  logic signed [ANGLE_W-1:0]   start_pose_r [JOINTS];
  logic signed [ANGLE_W-1:0]   start_pose_nxt [JOINTS];

  // Step walk
  logic [TIME_W-1:0]   qtime_r, qtime_nxt;
  logic [STEP_CW-1:0]  count_r, count_nxt;
  logic [STEP_CW-1:0]  step_r, step_nxt;
  logic [STEP_AW-1:0]  prev_step_r, prev_step_nxt;
  logic                has_prev_r, has_prev_nxt;
  logic                interp_r, interp_nxt;
  logic [TIME_W-1:0]   accum_r, accum_nxt;
  logic [TICK_W-1:0]   move_r, move_nxt;
  logic [TICK_W-1:0]   elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0]   span_r, span_nxt;

  // Per-joint interpolation
  logic [JOINT_AW-1:0]       joint_r, joint_nxt;
  logic signed [ANGLE_W-1:0] prev_ang_r, prev_ang_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic                      neg_r, neg_nxt;
  logic [TICK_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]          quo_r, quo_nxt;
  logic [DCNT_W-1:0]         dcnt_r, dcnt_nxt;

  logic              out_strobe_r, out_strobe_nxt;
  kpi_pkg::kpi_out_t out_data_r, out_data_nxt;

  // Memories
  logic                          tim_we, ang_we;
  logic [STEP_AW-1:0]            tim_waddr, tim_raddr;
  logic [kpi_pkg::TIM_W-1:0]     tim_wdata, tim_rdata;
  logic [ANGLE_AW-1:0]           ang_waddr, ang_raddr;
  logic [ANGLE_W-1:0]            ang_wdata, ang_rdata;

  logic                    step_ok, joint_ok;
  logic [TICK_W-1:0]       rd_pause, rd_move;
  logic [TIME_W:0]         sum_pause, sum_move;
  logic [CMP_W-1:0]        steps_ext;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]       diff_mag;
  logic [TICK_W:0]         trial;
  logic                    trial_ge;
  logic signed [QUO_W:0]   quo_s;
  logic signed [QUO_W:0]   sum_ang;

  // Write decode
  assign step_ok  = int'(in_data.step_number) < kpi_pkg::MAX_STEPS;
  assign joint_ok = int'(in_data.joint_number) < JOINTS;

  assign tim_we    = in_accept && (in_data.mode == kpi_pkg::MODE_TIMING) && step_ok;
  assign tim_waddr = STEP_AW'(in_data.step_number);
  assign tim_wdata = {in_data.pause_ticks, in_data.move_ticks};
  assign tim_raddr = step_r[STEP_AW-1:0];

  assign ang_we    = in_accept && (in_data.mode == kpi_pkg::MODE_ANGLE) && step_ok && joint_ok;
  assign ang_waddr = kpi_pkg::angle_addr(int'(in_data.step_number), int'(in_data.joint_number));
  assign ang_wdata = in_data.joint_angle;
  assign ang_raddr = cmd.prev_sel ? kpi_pkg::angle_addr(int'(prev_step_r), int'(joint_r))
                                  : kpi_pkg::angle_addr(int'(step_r), int'(joint_r));

  kpi_ram #(.WIDTH(kpi_pkg::TIM_W), .DEPTH(kpi_pkg::MAX_STEPS)) u_tim_ram (
    .clk   (clk),
    .we    (tim_we),
    .waddr (tim_waddr),
    .wdata (tim_wdata),
    .raddr (tim_raddr),
    .rdata (tim_rdata)
  );

  kpi_ram #(.WIDTH(ANGLE_W), .DEPTH(kpi_pkg::ANGLE_DEPTH)) u_ang_ram (
    .clk   (clk),
    .we    (ang_we),
    .waddr (ang_waddr),
    .wdata (ang_wdata),
    .raddr (ang_raddr),
    .rdata (ang_rdata)
  );

  assign rd_pause  = tim_rdata[kpi_pkg::TIM_W-1:TICK_W];
  assign rd_move   = tim_rdata[TICK_W-1:0];
  assign sum_pause = {1'b0, accum_r} + (TIME_W + 1)'(rd_pause);
  assign sum_move  = {1'b0, accum_r} + (TIME_W + 1)'(move_r);
  assign steps_ext = CMP_W'(steps_r);

  assign diff     = DIFF_W'(ang_rdata[ANGLE_W-1] ? {1'b1, ang_rdata} : {1'b0, ang_rdata})
                  - DIFF_W'(prev_ang_r);
  assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // One quotient bit per cycle; the remainder stays below the span
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, span_r};

  assign quo_s   = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign sum_ang = (QUO_W + 1)'(prev_ang_r) + quo_s;

  always_comb begin
    steps_nxt      = steps_r;
    start_pose_nxt = start_pose_r;
    qtime_nxt      = qtime_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    prev_step_nxt  = prev_step_r;
    has_prev_nxt   = has_prev_r;
    interp_nxt     = interp_r;
    accum_nxt      = accum_r;
    move_nxt       = move_r;
    elapsed_nxt    = elapsed_r;
    span_nxt       = span_r;
    joint_nxt      = joint_r;
    prev_ang_nxt   = prev_ang_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dcnt_nxt       = dcnt_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;

    if (cfg_we) steps_nxt = cfg_wdata;
    if (in_accept && (in_data.mode == kpi_pkg::MODE_START) && joint_ok) begin
      start_pose_nxt[JOINT_AW'(in_data.joint_number)] = in_data.joint_angle;
    end

    if (cmd.load_query) begin
      qtime_nxt    = in_data.query_time;
      count_nxt    = (steps_ext > CMP_W'(kpi_pkg::MAX_STEPS))
                   ? STEP_CW'(kpi_pkg::MAX_STEPS) : STEP_CW'(steps_ext);
      step_nxt     = '0;
      accum_nxt    = '0;
      has_prev_nxt = 1'b0;
      interp_nxt   = 1'b0;
      joint_nxt    = '0;
    end
    if (cmd.walk_pause) begin
      accum_nxt = TIME_W'(sum_pause);
      move_nxt  = rd_move;
    end
    if (cmd.walk_adv) begin
      accum_nxt     = TIME_W'(sum_move);
      prev_step_nxt = step_r[STEP_AW-1:0];
      has_prev_nxt  = 1'b1;
      step_nxt      = step_r + STEP_CW'(1);
    end
    if (cmd.set_interp) begin
      interp_nxt  = 1'b1;
      elapsed_nxt = TICK_W'(qtime_r - accum_r);
      span_nxt    = move_r;
    end
    if (cmd.take_prev) begin
      prev_ang_nxt = has_prev_r ? $signed(ang_rdata) : start_pose_r[joint_r];
    end
    if (cmd.mul) begin
      prod_nxt = PROD_W'(diff_mag) * PROD_W'(elapsed_r);
      neg_nxt  = diff[DIFF_W-1];
    end
    if (cmd.div_load) begin
      rem_nxt  = prod_r[PROD_W-1:QUO_W];
      quo_nxt  = prod_r[QUO_W-1:0];
      dcnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt  = trial_ge ? TICK_W'(trial - {1'b0, span_r}) : TICK_W'(trial);
      quo_nxt  = {quo_r[QUO_W-2:0], trial_ge};
      dcnt_nxt = dcnt_r + DCNT_W'(1);
    end
    if (cmd.emit) begin
      out_strobe_nxt          = 1'b1;
      out_data_nxt.out_joint  = kpi_pkg::JOINT_W'(joint_r);
      out_data_nxt.out_angle  = interp_r ? ANGLE_W'(sum_ang) : prev_ang_r;
      out_data_nxt.last_joint = (joint_r == JOINT_AW'(JOINTS - 1));
      joint_nxt               = joint_r + JOINT_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r      <= '0;
      start_pose_r <= '{default: '0};
      has_prev_r   <= 1'b0;
      interp_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      steps_r      <= steps_nxt;
      start_pose_r <= start_pose_nxt;
      has_prev_r   <= has_prev_nxt;
      interp_r     <= interp_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qtime_r     <= qtime_nxt;
    count_r     <= count_nxt;
    step_r      <= step_nxt;
    prev_step_r <= prev_step_nxt;
    accum_r     <= accum_nxt;
    move_r      <= move_nxt;
    elapsed_r   <= elapsed_nxt;
    span_r      <= span_nxt;
    joint_r     <= joint_nxt;
    prev_ang_r  <= prev_ang_nxt;
    prod_r      <= prod_nxt;
    neg_r       <= neg_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    dcnt_r      <= dcnt_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign sts.walk_done  = (step_r == count_r);
  assign sts.hit_pause  = {1'b0, qtime_r} <= sum_pause;
  assign sts.hit_move   = {1'b0, qtime_r} <= sum_move;
  assign sts.interp     = interp_r;
  assign sts.div_last   = (dcnt_r == DCNT_W'(QUO_W - 1));
  assign sts.joint_last = (joint_r == JOINT_AW'(JOINTS - 1));

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // A move found by the walk never has a zero span and never overruns it
  a_span_ok: assert property (@(posedge clk) disable iff (!rst_n)
    interp_r |-> (span_r != '0) && (elapsed_r <= span_r))
    else $error("interpolation span invalid");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < span_r)
    else $error("divider remainder out of range");

endmodule

[hw/rtl/keyframe_pose_interpolator.sv]
`timescale 1ns / 1ps
// Write items (modes 0..2) land at the accept edge and busy stays low.
// A query holds busy while it walks the steps (check, pause, move) until past the end, in a
// pause or in a move, then emits all 16 joints; multiply and divide run only inside a move.
// Results come one per joint, strobed for one cycle each; the receiver cannot stall them.
// Next item is taken as busy drops; the step walk and the bitwise divider set throughput.
// rst_n is synchronous: it clears the configured step count and the initial pose; step tables hold.

module keyframe_pose_interpolator (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  kpi_pkg::kpi_in_t            in_data,
  // result channel
  output logic                        out_strobe,
  output kpi_pkg::kpi_out_t           out_data,
  // configuration
  input  logic                        cfg_we,
  input  logic [kpi_pkg::STEPS_W-1:0] cfg_wdata
);

  logic              in_accept;
  logic              query_go;
  kpi_pkg::kpi_cmd_t cmd;
  kpi_pkg::kpi_sts_t sts;

  // A transfer on the command channel happens whenever start meets an idle block.
  // Writes are handled by the datapath directly; only a query wakes the controller.
  assign in_accept = start && !busy;
  assign query_go  = in_accept && (in_data.mode == kpi_pkg::MODE_QUERY);

  // Controller: walks the step list, then sequences per-joint read, multiply and divide.
  kpi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .query_go (query_go),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Datapath: step timing and angle memories, accumulator, multiplier, divider and
  // the registered result stage that drives the strobe.
  kpi_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
